@@ sv/itmd_pkg.sv @@
// ----------------------------------------------------------------------------
// itmd_pkg
// Shared types, widths, constants and the arctangent table for the IMU tilt
// and motion detector.
// ----------------------------------------------------------------------------
package itmd_pkg;

    // default parameter values
    localparam int WINDOW_MAX_DEF   = 256;
    localparam int CORDIC_STEPS_DEF = 16;

    // datapath widths
    localparam int ANG_W = 16;   // fused angle, 1/128 degree
    localparam int X_W   = 34;   // cordic x / y
    localparam int Z_W   = 26;   // cordic angle, 2^-16 degree
    localparam int G_W   = 30;   // gyro term, 2^-16 degree
    localparam int A_W   = 32;   // multiplier operand a
    localparam int B_W   = 22;   // multiplier operand b
    localparam int P_W   = A_W + B_W;

    // fixed-point constants
    localparam int ANGLE_LIMIT  = 23040;
    localparam int INV_GAIN     = 39797;
    localparam int QUARTER_TURN = 5898240;  // 90 degree in 2^-16 degree
    localparam int ROUND_FUSE   = 8388608;  // half of 2^24

    // configuration register indexes
    localparam logic [1:0] CFG_BLEND  = 2'd0;
    localparam logic [1:0] CFG_PERIOD = 2'd1;
    localparam logic [1:0] CFG_WINDOW = 2'd2;
    localparam logic [1:0] CFG_THRESH = 2'd3;

    // configuration reset values
    localparam logic [15:0] BLEND_RST  = 16'd31130;
    localparam logic [20:0] PERIOD_RST = 21'd10486;
    localparam logic [8:0]  WINDOW_RST = 9'd100;
    localparam logic [14:0] THRESH_RST = 15'd640;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_ITER,
        S_CEND,
        S_GAIN,
        S_LOAD,
        S_RATE,
        S_GYRO,
        S_AMUL,
        S_BMUL,
        S_FUSE,
        S_WIN,
        S_UPD,
        S_DP,
        S_DR,
        S_CMP
    } t_state;

    // atan(2^-i) in 2^-16 degree, rounded
    function automatic logic [21:0] atan_lut(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/imu_tilt_motion_detector.sv @@
// Sequence: a cordic pass for roll, gain correction of its magnitude, a cordic
// pass for pitch, then the filter for roll and pitch, the window update and
// the compare; the cordic iterations are skipped when an accelerometer vector
// is zero. The cordic stage and the multiplier are shared. Input is not ready
// while a sample is in work. A finished result waits in the output register.
// Reset: synchronous active low; restores register defaults, zero angles,
// empty window. Window memory contents are not cleared.
// ----------------------------------------------------------------------------
// imu_tilt_motion_detector
// Accelerometer tilt by cordic, complementary filter with gyro rates, and a
// moving-window deviation test on pitch and roll.
// ----------------------------------------------------------------------------
module imu_tilt_motion_detector
    import itmd_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [20:0]             i_cfg_data,
    // sample input
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [15:0]      i_accel_x,
    input  logic signed [15:0]      i_accel_y,
    input  logic signed [15:0]      i_accel_z,
    input  logic signed [15:0]      i_gyro_roll_rate,
    input  logic signed [15:0]      i_gyro_pitch_rate,
    // result output
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_motion_event,
    output logic signed [ANG_W-1:0] o_pitch_out,
    output logic signed [ANG_W-1:0] o_roll_out
);

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int LW    = (CW > 9) ? CW : 9;
    localparam int SUM_W = $clog2(WINDOW_MAX * ANGLE_LIMIT + 1) + 1;
    localparam int D_W   = SUM_W + 1;
    localparam int I_W   = $clog2(CORDIC_STEPS);

    t_state r_state, n_state;

    // configuration registers
    logic [15:0] r_blend;
    logic [20:0] r_period;
    logic [8:0]  r_wlen;
    logic [14:0] r_thresh;

    // latched sample fields
    logic signed [15:0] r_ax, r_gr, r_gp;

    // cordic state
    logic signed [X_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0] r_z;
    logic [I_W-1:0]        r_i;
    logic                  r_pass;
    logic signed [Z_W-1:0] r_roll_acc, r_pitch_acc;

    // filter state
    logic                  r_sel;
    logic signed [P_W-1:0] r_prod, r_t;
    logic signed [G_W-1:0] r_g;
    logic signed [ANG_W-1:0] r_pitch, r_roll;

    // window state
    logic [2*ANG_W-1:0]      r_mem [WINDOW_MAX];
    logic [2*ANG_W-1:0]      r_rd;
    logic [AW-1:0]           r_slot, r_wslot;
    logic [CW-1:0]           r_fill;
    logic signed [SUM_W-1:0] r_psum, r_rsum;
    logic [D_W-1:0]          r_dp, r_dr;

    // result register
    logic                    r_out_valid, r_event;
    logic signed [ANG_W-1:0] r_pitch_out, r_roll_out;

    // active window length, clamped to 1..WINDOW_MAX
    logic [CW-1:0] len;
    always_comb begin
        if (r_wlen == 9'd0) begin
            len = CW'(1);
        end else if (LW'(r_wlen) > LW'(WINDOW_MAX)) begin
            len = CW'(WINDOW_MAX);
        end else begin
            len = CW'(r_wlen);
        end
    end

    // blend weights
    logic [16:0] alpha, beta;
    assign alpha = (r_blend > 16'd32768) ? 17'd32768 : {1'b0, r_blend};
    assign beta  = 17'd32768 - alpha;

    // per-axis operand select
    logic signed [ANG_W-1:0] cur_angle;
    logic signed [15:0]      cur_rate;
    logic signed [Z_W-1:0]   cur_acc;
    assign cur_angle = r_sel ? r_pitch : r_roll;
    assign cur_rate  = r_sel ? r_gp : r_gr;
    assign cur_acc   = r_sel ? r_pitch_acc : r_roll_acc;

    // shared multiplier
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [P_W-1:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_GAIN: begin
                mul_a = A_W'(r_x);
                mul_b = B_W'(INV_GAIN);
            end
            S_RATE: begin
                mul_a = A_W'(cur_rate);
                mul_b = $signed(B_W'(r_period));
            end
            S_AMUL: begin
                mul_a = A_W'(r_g);
                mul_b = $signed(B_W'(alpha));
            end
            S_BMUL: begin
                mul_a = A_W'(cur_acc);
                mul_b = $signed(B_W'(beta));
            end
            S_UPD: begin
                mul_a = A_W'(r_pitch);
                mul_b = $signed(B_W'(len));
            end
            S_DP: begin
                mul_a = A_W'(r_roll);
                mul_b = $signed(B_W'(len));
            end
            S_DR: begin
                mul_a = $signed(A_W'(r_thresh));
                mul_b = $signed(B_W'(len));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // cordic micro-rotation
    logic signed [X_W-1:0] dx, dy;
    logic signed [Z_W-1:0] at;
    logic                  vec_zero, last_step;
    assign dx        = r_y >>> r_i;
    assign dy        = r_x >>> r_i;
    assign at        = $signed(Z_W'(atan_lut(5'(r_i))));
    assign vec_zero  = (r_x == '0) && (r_y == '0);
    assign last_step = (r_i == I_W'(CORDIC_STEPS - 1));

    // complementary filter output with rounding and saturation
    logic signed [P_W-1:0]   fuse_sum, fuse_sh;
    logic signed [ANG_W-1:0] fused;
    always_comb begin
        fuse_sum = r_t + r_prod + P_W'(ROUND_FUSE);
        fuse_sh  = fuse_sum >>> 24;
        if (fuse_sh > P_W'(ANGLE_LIMIT)) begin
            fused = ANG_W'(ANGLE_LIMIT);
        end else if (fuse_sh < -P_W'(ANGLE_LIMIT)) begin
            fused = -ANG_W'(ANGLE_LIMIT);
        end else begin
            fused = ANG_W'(fuse_sh);
        end
    end

    // gyro term: angle*512 plus rate*period/256, rounded
    logic signed [P_W-1:0] rate_rnd;
    assign rate_rnd = (r_prod + P_W'(128)) >>> 8;

    // window slot and deviations
    logic [AW-1:0]         slot_c, slot_inc;
    logic [CW-1:0]         slot_nxt;
    logic                  full_before;
    logic signed [D_W-1:0] dev;
    logic signed [SUM_W-1:0] old_p, old_r;
    assign slot_c      = (CW'(r_wslot) >= len) ? '0 : r_wslot;
    assign slot_nxt    = CW'(r_slot) + CW'(1);
    assign slot_inc    = (slot_nxt >= len) ? '0 : AW'(slot_nxt);
    assign full_before = (r_fill >= len);
    assign old_p = full_before ? SUM_W'($signed(r_rd[2*ANG_W-1:ANG_W])) : '0;
    assign old_r = full_before ? SUM_W'($signed(r_rd[ANG_W-1:0])) : '0;
    assign dev   = D_W'(r_prod) - D_W'(r_state == S_DP ? r_psum : r_rsum);

    logic [D_W-1:0] dev_abs;
    assign dev_abs = dev[D_W-1] ? D_W'(-dev) : D_W'(dev);

    logic event_c;
    assign event_c = (r_fill == len) &&
                     ((P_W'(r_dp) > $unsigned(r_prod)) ||
                      (P_W'(r_dr) > $unsigned(r_prod)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_PRE;
            S_PRE:  n_state = vec_zero ? S_CEND : S_ITER;
            S_ITER: if (last_step) n_state = S_CEND;
            S_CEND: n_state = r_pass ? S_RATE : S_GAIN;
            S_GAIN: n_state = S_LOAD;
            S_LOAD: n_state = S_PRE;
            S_RATE: n_state = S_GYRO;
            S_GYRO: n_state = S_AMUL;
            S_AMUL: n_state = S_BMUL;
            S_BMUL: n_state = S_FUSE;
            S_FUSE: n_state = r_sel ? S_WIN : S_RATE;
            S_WIN:  n_state = S_UPD;
            S_UPD:  n_state = S_DP;
            S_DP:   n_state = S_DR;
            S_DR:   n_state = S_CMP;
            S_CMP:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window memory
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[slot_c];
        if (r_state == S_UPD) begin
            r_mem[r_slot] <= {r_pitch, r_roll};
        end
    end

    // datapath without reset
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_IDLE: begin
                r_x  <= X_W'(i_accel_z) <<< 12;
                r_y  <= X_W'(i_accel_y) <<< 12;
                r_ax <= i_accel_x;
                r_gr <= i_gyro_roll_rate;
                r_gp <= i_gyro_pitch_rate;
            end
            S_PRE: begin
                r_i <= '0;
                if (vec_zero) begin
                    r_x <= '0;
                    r_z <= '0;
                end else if (r_x < 0) begin
                    if (r_y >= 0) begin
                        r_x <= r_y;
                        r_y <= -r_x;
                        r_z <= Z_W'(QUARTER_TURN);
                    end else begin
                        r_x <= -r_y;
                        r_y <= r_x;
                        r_z <= -Z_W'(QUARTER_TURN);
                    end
                end else begin
                    r_z <= '0;
                end
            end
            S_ITER: begin
                r_i <= r_i + I_W'(1);
                if (r_y >= 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end
            end
            S_CEND: begin
                if (r_pass) begin
                    r_pitch_acc <= r_z;
                end else begin
                    r_roll_acc <= r_z;
                end
            end
            S_LOAD: begin
                r_x <= X_W'(r_prod >>> 16);
                r_y <= -(X_W'(r_ax) <<< 12);
            end
            S_GYRO: begin
                r_g <= (G_W'(cur_angle) <<< 9) + G_W'(rate_rnd);
            end
            S_BMUL: begin
                r_t <= r_prod;
            end
            S_WIN: begin
                r_slot <= slot_c;
            end
            S_DP: begin
                r_dp <= dev_abs;
            end
            S_DR: begin
                r_dr <= dev_abs;
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend     <= BLEND_RST;
            r_period    <= PERIOD_RST;
            r_wlen      <= WINDOW_RST;
            r_thresh    <= THRESH_RST;
            r_pass      <= 1'b0;
            r_sel       <= 1'b0;
            r_pitch     <= '0;
            r_roll      <= '0;
            r_psum      <= '0;
            r_rsum      <= '0;
            r_wslot     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration transfer
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BLEND:  r_blend  <= i_cfg_data[15:0];
                    CFG_PERIOD: r_period <= i_cfg_data;
                    CFG_WINDOW: begin
                        r_wlen  <= i_cfg_data[8:0];
                        r_psum  <= '0;
                        r_rsum  <= '0;
                        r_wslot <= '0;
                        r_fill  <= '0;
                    end
                    CFG_THRESH: r_thresh <= i_cfg_data[14:0];
                    default:    r_thresh <= r_thresh;
                endcase
            end

            // result post and result transfer
            if (r_state == S_CMP && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: r_pass <= 1'b0;
                S_LOAD: r_pass <= 1'b1;
                S_CEND: r_sel  <= 1'b0;
                S_FUSE: begin
                    if (r_sel) begin
                        r_pitch <= fused;
                    end else begin
                        r_roll <= fused;
                        r_sel  <= 1'b1;
                    end
                end
                S_UPD: begin
                    r_psum  <= r_psum - old_p + SUM_W'(r_pitch);
                    r_rsum  <= r_rsum - old_r + SUM_W'(r_roll);
                    r_wslot <= slot_inc;
                    if (r_fill < len) r_fill <= r_fill + CW'(1);
                end
                default: r_pass <= r_pass;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP && (!r_out_valid || i_out_ready)) begin
            r_event     <= event_c;
            r_pitch_out <= r_pitch;
            r_roll_out  <= r_roll;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_motion_event = r_event;
    assign o_pitch_out    = r_pitch_out;
    assign o_roll_out     = r_roll_out;

`ifndef NO_ASSERTIONS
    // fill count never passes the active length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= len)
        else $error("fill count above window length");

    // write slot stays inside the window between samples
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (CW'(r_wslot) < len))
        else $error("write slot outside window");

    // an input transfer starts the cordic sequence
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_PRE))
        else $error("sample transfer did not start sequence");

    // a result is posted only from the compare step
    a_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_CMP))
        else $error("result posted outside compare step");
`endif

endmodule

@@ tb/sv/imu_tilt_motion_detector_checker.sv @@
// ----------------------------------------------------------------------------
// imu_tilt_motion_detector_checker
// Watches the config, sample and result channels, predicts each fused
// pitch/roll and motion flag from its own model, and compares in order.
// ----------------------------------------------------------------------------
module imu_tilt_motion_detector_checker
    import itmd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [20:0]             i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic signed [15:0]      i_accel_x,
    input  logic signed [15:0]      i_accel_y,
    input  logic signed [15:0]      i_accel_z,
    input  logic signed [15:0]      i_gyro_roll_rate,
    input  logic signed [15:0]      i_gyro_pitch_rate,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_motion_event,
    input  logic signed [15:0]      i_pitch_out,
    input  logic signed [15:0]      i_roll_out,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               motion;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } t_tilt;

    t_tilt       tilt_q[$];
    logic [15:0] alpha_reg;
    logic [20:0] period_reg;
    logic [8:0]  wlen_reg;
    logic [14:0] thresh_reg;
    longint      pitch_now, roll_now, pitch_acc_sum, roll_acc_sum;
    longint      pitch_hist[256], roll_hist[256];
    int          slot_ptr, fill_cnt;

    assign o_pending = tilt_q.size();

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    // vectoring cordic, angle in 2^-16 degree
    function automatic longint vec_angle(longint x, longint y, output longint mag);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) begin
            mag = 0;
            return 0;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = QUARTER_TURN;
            end else begin
                x = -y; y = t; z = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(atan_lut(i[4:0]));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_lut(i[4:0]));
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint blend(longint ang, longint rate, longint acc);
        longint a, g, r;
        a = (alpha_reg > 16'd32768) ? 32768 : longint'(alpha_reg);
        g = ang * 512 + fshr(rate * longint'(period_reg) + 128, 8);
        r = fshr(a * g + (32768 - a) * acc + ROUND_FUSE, 24);
        if (r > ANGLE_LIMIT) r = ANGLE_LIMIT;
        if (r < -ANGLE_LIMIT) r = -ANGLE_LIMIT;
        return r;
    endfunction

    function automatic t_tilt predict_tilt(longint ax, longint ay, longint az,
                                           longint gr, longint gp);
        longint mag, dummy, r_acc, p_acc, len, dp, dr;
        int     s;
        t_tilt  res;
        len = (wlen_reg == 0) ? 1 : ((wlen_reg > 256) ? 256 : longint'(wlen_reg));
        r_acc = vec_angle(az * 4096, ay * 4096, mag);
        mag = fshr(mag * INV_GAIN, 16);
        p_acc = vec_angle(mag, -ax * 4096, dummy);
        roll_now = blend(roll_now, gr, r_acc);
        pitch_now = blend(pitch_now, gp, p_acc);
        s = (slot_ptr >= len) ? 0 : slot_ptr;
        if (fill_cnt >= len) begin
            pitch_acc_sum -= pitch_hist[s];
            roll_acc_sum -= roll_hist[s];
        end
        pitch_hist[s] = pitch_now;
        roll_hist[s] = roll_now;
        pitch_acc_sum += pitch_now;
        roll_acc_sum += roll_now;
        s++;
        slot_ptr = (s >= len) ? 0 : s;
        if (fill_cnt < len) fill_cnt++;
        res.motion = 1'b0;
        if (fill_cnt == len) begin
            dp = pitch_now * len - pitch_acc_sum;
            dr = roll_now * len - roll_acc_sum;
            if (dp < 0) dp = -dp;
            if (dr < 0) dr = -dr;
            res.motion = (dp > thresh_reg * len) || (dr > thresh_reg * len);
        end
        res.pitch = pitch_now[15:0];
        res.roll = roll_now[15:0];
        return res;
    endfunction

    // watch transfers on all channels
    always @(posedge i_clk) begin
        t_tilt want;
        if (!i_rst_n) begin
            alpha_reg <= BLEND_RST;
            period_reg <= PERIOD_RST;
            wlen_reg <= WINDOW_RST;
            thresh_reg <= THRESH_RST;
            pitch_now = 0; roll_now = 0;
            pitch_acc_sum = 0; roll_acc_sum = 0;
            slot_ptr = 0; fill_cnt = 0;
            tilt_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BLEND:  alpha_reg <= i_cfg_data[15:0];
                    CFG_PERIOD: period_reg <= i_cfg_data;
                    CFG_WINDOW: begin
                        wlen_reg <= i_cfg_data[8:0];
                        pitch_acc_sum = 0; roll_acc_sum = 0;
                        slot_ptr = 0; fill_cnt = 0;
                    end
                    default:    thresh_reg <= i_cfg_data[14:0];
                endcase
            end
            if (i_in_valid && i_in_ready)
                tilt_q.insert(tilt_q.size(),
                              predict_tilt(longint'(i_accel_x), longint'(i_accel_y),
                                           longint'(i_accel_z),
                                           longint'(i_gyro_roll_rate),
                                           longint'(i_gyro_pitch_rate)));
            if (i_out_valid && i_out_ready) begin
                if (tilt_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %b %0d %0d", $time,
                             i_motion_event, i_pitch_out, i_roll_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = tilt_q[0];
                    tilt_q.delete(0);
                    if (want.motion !== i_motion_event || want.pitch !== i_pitch_out
                        || want.roll !== i_roll_out) begin
                        $display("%0t: expected ev %b pitch %0d roll %0d, got %b %0d %0d",
                                 $time, want.motion, want.pitch, want.roll,
                                 i_motion_event, i_pitch_out, i_roll_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ tb/sv/imu_tilt_motion_detector_test.sv @@
// ----------------------------------------------------------------------------
// imu_tilt_motion_detector_test
// Drives directed and random IMU samples through several register settings
// with random idling; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module imu_tilt_motion_detector_test;
    import itmd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 1'b0, rst_n = 1'b0;
    logic              cfg_valid = 1'b0, cfg_ready;
    logic [1:0]        cfg_index = CFG_BLEND;
    logic [20:0]       cfg_data = '0;
    logic              in_valid = 1'b0, in_ready;
    logic signed [15:0] ax = '0, ay = '0, az = '0, gr = '0, gp = '0;
    logic              out_valid, out_ready = 1'b0;
    logic              motion_event;
    logic signed [15:0] pitch_out, roll_out;
    int                fail_count, pending;
    bit                calm = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    imu_tilt_motion_detector dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_accel_x(ax), .i_accel_y(ay), .i_accel_z(az),
        .i_gyro_roll_rate(gr), .i_gyro_pitch_rate(gp),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_motion_event(motion_event), .o_pitch_out(pitch_out), .o_roll_out(roll_out)
    );

    imu_tilt_motion_detector_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_accel_x(ax), .i_accel_y(ay), .i_accel_z(az),
        .i_gyro_roll_rate(gr), .i_gyro_pitch_rate(gp),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_motion_event(motion_event), .i_pitch_out(pitch_out), .i_roll_out(roll_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // result side back-pressure
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 13);

    // valid stays up after the transfer; the next sample drops it
    task automatic write_reg(logic [1:0] idx, int val);
        cfg_index <= idx;
        cfg_data <= 21'(val);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // valid stays up after the transfer; idling, the next call or drain drops it
    task automatic send_sample(int x, int y, int z, int r, int p);
        cfg_valid <= 1'b0;
        while (!calm && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        ax <= 16'(x); ay <= 16'(y); az <= 16'(z); gr <= 16'(r); gp <= 16'(p);
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // tilted-but-steady samples with modest noise, occasional jolts
    task automatic random_burst(int n);
        int bx, by, bz;
        bx = $urandom_range(2000) - 1000;
        by = $urandom_range(2000) - 1000;
        bz = $urandom_range(2000) - 1000;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0)
                send_sample($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                send_sample(bx + $urandom_range(40) - 20, by + $urandom_range(40) - 20,
                            bz + $urandom_range(40) - 20, $urandom_range(200) - 100,
                            $urandom_range(200) - 100);
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, zero vector, negative z, saturation
        write_reg(CFG_WINDOW, 1);
        send_sample(0, 0, 0, 0, 0);
        send_sample('h8000, 'h8000, 'h8000, 'h8000, 'h8000);
        send_sample('h7fff, 'h7fff, 'h7fff, 'h7fff, 'h7fff);
        send_sample(0, 1000, -1000, 0, 0);
        send_sample(0, -1000, -1000, 0, 0);
        send_sample(-1000, 0, 1000, 0, 0);
        send_sample('hffff, 'hffff, 'hffff, 'hffff, 'hffff);
        send_sample('h5555, 'haaaa, 'h5555, 'haaaa, 'h5555);
        drain();
        write_reg(CFG_BLEND, 65535);
        write_reg(CFG_PERIOD, 'h1fffff);
        write_reg(CFG_WINDOW, 0);
        write_reg(CFG_THRESH, 0);
        for (int k = 0; k < 6; k++) send_sample(0, 0, 1000, 'h7fff, 'h8000);
        drain();
        write_reg(CFG_BLEND, 0);
        write_reg(CFG_PERIOD, 1);
        write_reg(CFG_WINDOW, 511);
        write_reg(CFG_THRESH, 'h7fff);
        send_sample(1000, 0, 0, 0, 0);
        send_sample('h8000, 0, 'h7fff, 0, 0);
        drain();
        // random phases over settings
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            write_reg(CFG_BLEND, (ph == 0) ? 32768 : int'($urandom_range(32768)));
            write_reg(CFG_PERIOD, (ph == 1) ? 1048576 : int'($urandom_range(1048576, 1)));
            write_reg(CFG_WINDOW, (ph == 2) ? 256 : int'($urandom_range(40, 1)));
            write_reg(CFG_THRESH, (ph == 4) ? 23040 : int'($urandom_range(1500)));
            random_burst(ph == 2 ? 400 : 200);
            drain();
        end
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
